// ----- hdl/aden_pkg.sv -----
// ----------------------------------------------------------------------------
// Attack/decay envelope package
// Shared constants, state encodings and register indexes of the envelope.
// ----------------------------------------------------------------------------
`default_nettype none

package aden_pkg;

    // Default sizes of the counters and of the level fraction.
    localparam int COUNT_WIDTH_DEF     = 24;
    localparam int LEVEL_FRAC_BITS_DEF = 15;

    // Fraction bits of the curve position and of the curve value.
    localparam int CURVE_FRAC_BITS = 20;

    // Step counter covers the longest serial pass (curve division).
    localparam int STEP_W = $clog2(CURVE_FRAC_BITS + 3);

    // Register reset values, in sample ticks and Q1.15.
    localparam int ATTACK_LEN_RST = 2400;
    localparam int DECAY_LEN_RST  = 24000;
    localparam int START_LVL_RST  = 0;
    localparam int END_LVL_RST    = 0;

    localparam int INPUT_TDATA_W = 8;
    localparam int CFG_INDEX_W   = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ATTACK_LEN = 2'd0,
        CFG_DECAY_LEN  = 2'd1,
        CFG_START_LVL  = 2'd2,
        CFG_END_LVL    = 2'd3
    } t_cfg_reg;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_ATTACK = 2'd1,
        PH_DECAY  = 2'd2
    } t_phase;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIVX,
        S_XDONE,
        S_SQR,
        S_DSETUP,
        S_DIVS,
        S_SCALE,
        S_MUL,
        S_LEVEL,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// ----- hdl/attack_decay_sigmoid_envelope.sv -----
// A tick in idle, a zero-length stage or the last attack tick goes from idle straight
// to the done state; other attack ticks pass the position divider, curve divider and
// scaling multiplier first, and decay ticks also square the position before the division.
// Ticks are worked one at a time; the input opens again as the result is loaded.
// Reset (synchronous, active low) returns the envelope to idle with elapsed count zero
// and the registers to 2400, 24000, 0 and 0.
// ----------------------------------------------------------------------------
// Attack/decay sigmoid envelope
// Per sample tick, one envelope level along a rational sigmoid, computed with
// a restoring divider and a shift-add multiplier, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module attack_decay_sigmoid_envelope #(
    parameter int COUNT_WIDTH     = aden_pkg::COUNT_WIDTH_DEF,
    parameter int LEVEL_FRAC_BITS = aden_pkg::LEVEL_FRAC_BITS_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // Configuration writes.
    input  wire logic                                   i_cfg_we,
    input  wire logic [aden_pkg::CFG_INDEX_W-1:0]       i_cfg_index,
    input  wire logic [((COUNT_WIDTH > LEVEL_FRAC_BITS + 1) ?
                        COUNT_WIDTH : LEVEL_FRAC_BITS + 1)-1:0] i_cfg_data,
    // Tick stream in.
    input  wire logic                                   i_s_axis_tvalid,
    output logic                                        o_s_axis_tready,
    input  wire logic [aden_pkg::INPUT_TDATA_W-1:0]     i_s_axis_tdata,  // [0] trigger
    // Level stream out.
    output logic                                        o_m_axis_tvalid,
    input  wire logic                                   i_m_axis_tready,
    output logic [((LEVEL_FRAC_BITS + 8) / 8) * 8-1:0]  o_m_axis_tdata   // level
);

    localparam int CW       = COUNT_WIDTH;
    localparam int LEVEL_W  = LEVEL_FRAC_BITS + 1;
    localparam int XF       = aden_pkg::CURVE_FRAC_BITS;
    localparam int XW       = XF + 1;
    localparam int QW       = XF + 2;
    localparam int A_W      = (LEVEL_W > XW) ? LEVEL_W : XW;
    localparam int B_W      = XW;
    localparam int PW       = A_W + B_W;
    localparam int DW       = 2 * XF + 4;
    localparam int OUT_TD_W = ((LEVEL_FRAC_BITS + 8) / 8) * 8;
    localparam int SW       = aden_pkg::STEP_W;

    localparam logic [LEVEL_W-1:0] LVL_ONE = {1'b1, {LEVEL_FRAC_BITS{1'b0}}};
    localparam logic [XW-1:0]      X_ONE   = {1'b1, {XF{1'b0}}};

    // Configuration registers.
    logic [CW-1:0]      r_attack_len;
    logic [CW-1:0]      r_decay_len;
    logic [LEVEL_W-1:0] r_start_lvl;
    logic [LEVEL_W-1:0] r_end_lvl;

    // Control state.
    aden_pkg::t_state r_state, n_state;
    aden_pkg::t_phase r_phase, n_phase;
    logic [CW-1:0]    r_elapsed, n_elapsed;
    logic [SW-1:0]    r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;

    // Datapath.
    logic               r_decay, n_decay;
    logic               r_xsat, n_xsat;
    logic [CW-1:0]      r_len, n_len;
    logic [CW-1:0]      r_rem, n_rem;
    logic [XW-1:0]      r_x, n_x;
    logic [DW:0]        r_num, n_num;
    logic [DW-1:0]      r_den, n_den;
    logic [QW-1:0]      r_q, n_q;
    logic [A_W-1:0]     r_mcand, n_mcand;
    logic [PW-1:0]      r_prod, n_prod;
    logic [LEVEL_W-1:0] r_base, n_base;
    logic [LEVEL_W-1:0] r_res, n_res;
    logic [LEVEL_W-1:0] r_out_level, n_out_level;

    // Combinational helpers.
    logic               accept;
    logic               out_free;
    logic               trig;
    aden_pkg::t_phase   ph_eff;
    logic [CW-1:0]      e_eff;
    logic [CW:0]        e_inc_full;
    logic [CW-1:0]      len_sel;
    logic               stage_end;
    logic [LEVEL_W-1:0] st_c;
    logic [LEVEL_W-1:0] en_c;
    logic [CW:0]        divx_r2;
    logic               divx_bit;
    logic               divs_bit;
    logic [DW:0]        divs_diff;
    logic [A_W:0]       mul_sum;
    logic [PW-1:0]      mul_next;
    logic [XW-1:0]      x_val;
    logic [DW-1:0]      x_d;
    logic [DW-1:0]      x2_d;
    logic [QW:0]        q_inc;
    logic [PW:0]        rnd;
    logic [LEVEL_W-1:0] t_lvl;

    assign st_c = (r_start_lvl > LVL_ONE) ? LVL_ONE : r_start_lvl;
    assign en_c = (r_end_lvl > LVL_ONE) ? LVL_ONE : r_end_lvl;

    assign o_s_axis_tready = (r_state == aden_pkg::S_IDLE);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_TD_W'(r_out_level);

    // Tick decision terms.
    assign trig       = i_s_axis_tdata[0];
    assign ph_eff     = trig ? aden_pkg::PH_ATTACK : r_phase;
    assign e_eff      = trig ? '0 : r_elapsed;
    assign e_inc_full = {1'b0, e_eff} + (CW+1)'(1);
    assign len_sel    = (ph_eff == aden_pkg::PH_DECAY) ? r_decay_len : r_attack_len;
    assign stage_end  = e_inc_full[CW] || (e_inc_full[CW-1:0] >= len_sel);

    // Position divider step: remainder doubles, one quotient bit per cycle.
    assign divx_r2  = {r_rem, 1'b0};
    assign divx_bit = (divx_r2 >= {1'b0, r_len});

    // Curve divider step.
    assign divs_bit  = (r_num >= {1'b0, r_den});
    assign divs_diff = divs_bit ? (r_num - {1'b0, r_den}) : r_num;

    // Shift-add multiplier step, multiplier bits leave at the bottom.
    assign mul_sum  = {1'b0, r_prod[PW-1:B_W]} + (r_prod[0] ? {1'b0, r_mcand} : '0);
    assign mul_next = {mul_sum, r_prod[B_W-1:1]};

    assign x_val = r_xsat ? X_ONE : r_x;
    assign x_d   = DW'(r_x);
    assign x2_d  = DW'(r_prod[2*XF:0]);

    // Curve value rounds to nearest: one extra quotient bit, add one, drop it.
    assign q_inc = {1'b0, r_q} + (QW+1)'(1);

    assign rnd   = {1'b0, r_prod} + ((PW+1)'(1) << (XF - 1));
    assign t_lvl = rnd[XF+LEVEL_W-1:XF];

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_elapsed   = r_elapsed;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_level = r_out_level;
        n_decay     = r_decay;
        n_xsat      = r_xsat;
        n_len       = r_len;
        n_rem       = r_rem;
        n_x         = r_x;
        n_num       = r_num;
        n_den       = r_den;
        n_q         = r_q;
        n_mcand     = r_mcand;
        n_prod      = r_prod;
        n_base      = r_base;
        n_res       = r_res;

        unique case (r_state)
            aden_pkg::S_IDLE: begin
                if (accept) begin
                    n_len  = len_sel;
                    n_rem  = e_eff;
                    n_xsat = (e_eff >= len_sel);
                    n_x    = '0;
                    n_cnt  = '0;
                    unique case (ph_eff)
                        aden_pkg::PH_ATTACK: begin
                            if (r_attack_len == '0 || stage_end) begin
                                n_res     = LVL_ONE;
                                n_phase   = aden_pkg::PH_DECAY;
                                n_elapsed = '0;
                                n_state   = aden_pkg::S_DONE;
                            end else begin
                                n_phase   = aden_pkg::PH_ATTACK;
                                n_elapsed = e_inc_full[CW-1:0];
                                n_decay   = 1'b0;
                                n_base    = st_c;
                                n_state   = aden_pkg::S_DIVX;
                            end
                        end
                        aden_pkg::PH_DECAY: begin
                            if (r_decay_len == '0) begin
                                n_res     = en_c;
                                n_phase   = aden_pkg::PH_IDLE;
                                n_elapsed = '0;
                                n_state   = aden_pkg::S_DONE;
                            end else begin
                                n_decay = 1'b1;
                                n_base  = en_c;
                                n_state = aden_pkg::S_DIVX;
                                if (stage_end) begin
                                    n_phase   = aden_pkg::PH_IDLE;
                                    n_elapsed = '0;
                                end else begin
                                    n_elapsed = e_inc_full[CW-1:0];
                                end
                            end
                        end
                        default: begin
                            // Idle, and the unused phase code, hold the end level.
                            n_res   = en_c;
                            n_state = aden_pkg::S_DONE;
                        end
                    endcase
                end
            end
            aden_pkg::S_DIVX: begin
                n_rem = divx_bit ? CW'(divx_r2 - {1'b0, r_len}) : divx_r2[CW-1:0];
                n_x   = {r_x[XW-2:0], divx_bit};
                n_cnt = r_cnt + SW'(1);
                if (r_cnt == SW'(XF - 1)) begin
                    n_state = aden_pkg::S_XDONE;
                end
            end
            aden_pkg::S_XDONE: begin
                n_x   = x_val;
                n_cnt = '0;
                if (r_decay) begin
                    n_mcand = A_W'(x_val);
                    n_prod  = PW'(x_val);
                    n_state = aden_pkg::S_SQR;
                end else begin
                    // Attack curve 5x / (3 + 2x).
                    n_num   = (DW+1)'((DW'(x_val) << 2) + DW'(x_val));
                    n_den   = (DW'(3) << XF) + (DW'(x_val) << 1);
                    n_q     = '0;
                    n_state = aden_pkg::S_DIVS;
                end
            end
            aden_pkg::S_SQR: begin
                n_prod = mul_next;
                n_cnt  = r_cnt + SW'(1);
                if (r_cnt == SW'(B_W - 1)) begin
                    n_state = aden_pkg::S_DSETUP;
                end
            end
            aden_pkg::S_DSETUP: begin
                // Decay curve x(7 + x) / (1 + 5x + 2x^2).
                n_num   = (DW+1)'((((x_d << 3) - x_d) << XF) + x2_d);
                n_den   = (DW'(1) << (2 * XF)) + (((x_d << 2) + x_d) << XF) + (x2_d << 1);
                n_q     = '0;
                n_cnt   = '0;
                n_state = aden_pkg::S_DIVS;
            end
            aden_pkg::S_DIVS: begin
                n_num = {divs_diff[DW-1:0], 1'b0};
                n_q   = {r_q[QW-2:0], divs_bit};
                n_cnt = r_cnt + SW'(1);
                if (r_cnt == SW'(QW - 1)) begin
                    n_state = aden_pkg::S_SCALE;
                end
            end
            aden_pkg::S_SCALE: begin
                n_mcand = A_W'(LVL_ONE - r_base);
                n_prod  = PW'(q_inc[QW-1:1]);
                n_cnt   = '0;
                n_state = aden_pkg::S_MUL;
            end
            aden_pkg::S_MUL: begin
                n_prod = mul_next;
                n_cnt  = r_cnt + SW'(1);
                if (r_cnt == SW'(B_W - 1)) begin
                    n_state = aden_pkg::S_LEVEL;
                end
            end
            aden_pkg::S_LEVEL: begin
                n_res   = r_decay ? (LVL_ONE - t_lvl) : (r_base + t_lvl);
                n_state = aden_pkg::S_DONE;
            end
            aden_pkg::S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_level = r_res;
                    n_state     = aden_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = aden_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack_len <= CW'(aden_pkg::ATTACK_LEN_RST);
            r_decay_len  <= CW'(aden_pkg::DECAY_LEN_RST);
            r_start_lvl  <= LEVEL_W'(aden_pkg::START_LVL_RST);
            r_end_lvl    <= LEVEL_W'(aden_pkg::END_LVL_RST);
        end else if (i_cfg_we) begin
            unique case (aden_pkg::t_cfg_reg'(i_cfg_index))
                aden_pkg::CFG_ATTACK_LEN: r_attack_len <= i_cfg_data[CW-1:0];
                aden_pkg::CFG_DECAY_LEN:  r_decay_len  <= i_cfg_data[CW-1:0];
                aden_pkg::CFG_START_LVL:  r_start_lvl  <= i_cfg_data[LEVEL_W-1:0];
                aden_pkg::CFG_END_LVL:    r_end_lvl    <= i_cfg_data[LEVEL_W-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= aden_pkg::S_IDLE;
            r_phase     <= aden_pkg::PH_IDLE;
            r_elapsed   <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_elapsed   <= n_elapsed;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_level <= n_out_level;
        r_decay     <= n_decay;
        r_xsat      <= n_xsat;
        r_len       <= n_len;
        r_rem       <= n_rem;
        r_x         <= n_x;
        r_num       <= n_num;
        r_den       <= n_den;
        r_q         <= n_q;
        r_mcand     <= n_mcand;
        r_prod      <= n_prod;
        r_base      <= n_base;
        r_res       <= n_res;
    end

endmodule

`default_nettype wire

// ----- hdl/aden_chk.sv -----
// ----------------------------------------------------------------------------
// Attack/decay envelope port checker
// Watches the envelope's stream ports and flags behavior it must never show.
// ----------------------------------------------------------------------------
`default_nettype none

module aden_chk #(
    parameter int LEVEL_FRAC_BITS = aden_pkg::LEVEL_FRAC_BITS_DEF
) (
    input wire logic                                  i_clk,
    input wire logic                                  i_rst_n,
    input wire logic                                  i_s_axis_tvalid,
    input wire logic                                  i_s_axis_tready,
    input wire logic                                  i_m_axis_tvalid,
    input wire logic                                  i_m_axis_tready,
    input wire logic [((LEVEL_FRAC_BITS + 8) / 8) * 8-1:0] i_m_axis_tdata
);

    localparam int LEVEL_W = LEVEL_FRAC_BITS + 1;
    localparam logic [LEVEL_W-1:0] LVL_ONE = {1'b1, {LEVEL_FRAC_BITS{1'b0}}};

    // A stalled result keeps its level.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid && !i_m_axis_tready |=>
            i_m_axis_tvalid && $stable(i_m_axis_tdata))
        else $error("stalled level changed or was dropped");

    // A level never goes above full scale.
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid |-> (i_m_axis_tdata[LEVEL_W-1:0] <= LVL_ONE))
        else $error("level above full scale");

    // Ticks are worked one at a time: a transfer closes the input in the next cycle.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && i_s_axis_tready |=> !i_s_axis_tready)
        else $error("input taken while a tick is in progress");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_axis_tvalid)
        else $error("result pending after reset");

endmodule

bind attack_decay_sigmoid_envelope aden_chk #(
    .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
) u_aden_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .i_s_axis_tready (o_s_axis_tready),
    .i_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .i_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire
